### hdl/lpse_pkg.sv
package lpse_pkg;

	localparam int MAX_LEDS        = 1024;
	localparam int RESET_GAP_BYTES = 64;

	localparam int COLOR_W    = 8;
	localparam int BRIGHT_W   = 8;
	localparam int LEN_W      = 11;
	localparam int POS_W      = $clog2(MAX_LEDS);
	localparam int WORD_W     = 24;
	localparam int CNT_W      = 2;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 11;

	localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LED_COUNT  = 1'd1;

	localparam logic [BRIGHT_W-1:0] BRIGHTNESS_RST = 8'd128;
	localparam logic [LEN_W-1:0]    LED_COUNT_RST  = 11'd1;
	localparam logic [LEN_W-1:0]    MAX_LEN        = LEN_W'(MAX_LEDS);

	localparam logic [2:0] PAT_ONE  = 3'b110;
	localparam logic [2:0] PAT_ZERO = 3'b100;

	// gap is packed three bytes per word, tail word may be short
	localparam int GAP_WORDS  = (RESET_GAP_BYTES + 2) / 3;
	localparam int WORDS_MAX  = 3 + GAP_WORDS;
	localparam int WC_W       = $clog2(WORDS_MAX);
	localparam int GAP_TAIL   = (GAP_WORDS == 0) ? 3 : RESET_GAP_BYTES - 3 * (GAP_WORDS - 1);

	localparam logic [CNT_W-1:0] BYTES_FULL = 2'd3;
	localparam logic [CNT_W-1:0] BYTES_TAIL = CNT_W'(GAP_TAIL);

	localparam logic [WC_W-1:0] WC_GREEN = WC_W'(0);
	localparam logic [WC_W-1:0] WC_RED   = WC_W'(1);
	localparam logic [WC_W-1:0] WC_BLUE  = WC_W'(2);
	localparam logic [WC_W-1:0] WC_LAST  = WC_W'(WORDS_MAX - 1);

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] blue;
		logic               last;
	} pix_t;

	function automatic logic [WORD_W-1:0] encode_channel(input logic [COLOR_W-1:0] v);
		logic [WORD_W-1:0] w;
		w = '0;
		for (int i = 0; i < COLOR_W; i++) begin
			w[3*i +: 3] = v[i] ? PAT_ONE : PAT_ZERO;
		end
		return w;
	endfunction

endpackage

### hdl/lpse_front.sv
module lpse_front (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [lpse_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [lpse_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                 pixel_valid,
	output logic                                 pixel_ready,
	input  logic [lpse_pkg::COLOR_W-1:0]         red,
	input  logic [lpse_pkg::COLOR_W-1:0]         green,
	input  logic [lpse_pkg::COLOR_W-1:0]         blue,
	input  logic                                 q_full,
	output logic                                 q_push,
	output lpse_pkg::pix_t                       q_wdata
);

	logic [lpse_pkg::BRIGHT_W-1:0] brightness_q;
	logic [lpse_pkg::LEN_W-1:0]    led_count_q;
	logic [lpse_pkg::POS_W-1:0]    pos_q;
	logic [lpse_pkg::LEN_W-1:0]    frame_len;
	logic [lpse_pkg::LEN_W-1:0]    pos_inc;
	logic                          last;
	logic [2*lpse_pkg::COLOR_W-1:0] prod_g, prod_r, prod_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			brightness_q <= lpse_pkg::BRIGHTNESS_RST;
			led_count_q  <= lpse_pkg::LED_COUNT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				lpse_pkg::REG_BRIGHTNESS: brightness_q <= cfg_data[lpse_pkg::BRIGHT_W-1:0];
				lpse_pkg::REG_LED_COUNT:  led_count_q  <= cfg_data[lpse_pkg::LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// zero length acts as one, oversized length clamps
	always_comb begin
		if (led_count_q == '0)
			frame_len = lpse_pkg::LEN_W'(1);
		else if (led_count_q > lpse_pkg::MAX_LEN)
			frame_len = lpse_pkg::MAX_LEN;
		else
			frame_len = led_count_q;
	end

	assign pos_inc = lpse_pkg::LEN_W'(pos_q) + lpse_pkg::LEN_W'(1);
	assign last    = pos_inc >= frame_len;

	assign prod_g = green * brightness_q;
	assign prod_r = red * brightness_q;
	assign prod_b = blue * brightness_q;

	assign pixel_ready = !q_full;
	assign q_push      = pixel_valid && pixel_ready;

	always_comb begin
		q_wdata.green = prod_g[2*lpse_pkg::COLOR_W-1:lpse_pkg::COLOR_W];
		q_wdata.red   = prod_r[2*lpse_pkg::COLOR_W-1:lpse_pkg::COLOR_W];
		q_wdata.blue  = prod_b[2*lpse_pkg::COLOR_W-1:lpse_pkg::COLOR_W];
		q_wdata.last  = last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (q_push) begin
			pos_q <= last ? '0 : pos_inc[lpse_pkg::POS_W-1:0];
		end
	end

endmodule

### hdl/lpse_queue.sv
module lpse_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  lpse_pkg::pix_t wdata,
	input  logic           pop,
	output lpse_pkg::pix_t rdata,
	output logic           full,
	output logic           nonempty
);

	lpse_pkg::pix_t                entries_q [lpse_pkg::QUEUE_DEPTH];
	logic [lpse_pkg::QPTR_W-1:0]   wr_q, rd_q;
	logic [lpse_pkg::QCNT_W-1:0]   count_q;

	assign full     = count_q == lpse_pkg::QCNT_W'(lpse_pkg::QUEUE_DEPTH);
	assign nonempty = count_q != '0;
	assign rdata    = entries_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + lpse_pkg::QPTR_W'(1);
			if (pop)
				rd_q <= rd_q + lpse_pkg::QPTR_W'(1);
			if (push && !pop)
				count_q <= count_q + lpse_pkg::QCNT_W'(1);
			else if (pop && !push)
				count_q <= count_q - lpse_pkg::QCNT_W'(1);
		end
	end

endmodule

### hdl/lpse_back.sv
module lpse_back (
	input  logic                             clk,
	input  logic                             arst_n,
	input  lpse_pkg::pix_t                   head,
	input  logic                             head_valid,
	output logic                             q_pop,
	output logic                             spi_valid,
	input  logic                             spi_ready,
	output logic [lpse_pkg::WORD_W-1:0]      spi_data,
	output logic [lpse_pkg::CNT_W-1:0]       byte_count,
	output logic                             frame_end
);

	logic [lpse_pkg::WC_W-1:0]   wc_q;
	logic                        spi_valid_q;
	logic [lpse_pkg::WORD_W-1:0] data_q;
	logic [lpse_pkg::CNT_W-1:0]  count_q;
	logic                        end_q;
	logic                        load;
	logic                        is_final;
	logic                        is_tail;
	logic [lpse_pkg::WORD_W-1:0] word;

	assign is_final = head.last ? (wc_q == lpse_pkg::WC_LAST) : (wc_q == lpse_pkg::WC_BLUE);
	assign is_tail  = head.last && (wc_q == lpse_pkg::WC_LAST) && (lpse_pkg::GAP_WORDS > 0);
	assign load     = head_valid && (!spi_valid_q || spi_ready);
	assign q_pop    = load && is_final;

	always_comb begin
		case (wc_q)
			lpse_pkg::WC_GREEN: word = lpse_pkg::encode_channel(head.green);
			lpse_pkg::WC_RED:   word = lpse_pkg::encode_channel(head.red);
			lpse_pkg::WC_BLUE:  word = lpse_pkg::encode_channel(head.blue);
			default:            word = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wc_q        <= '0;
			spi_valid_q <= 1'b0;
		end else if (load) begin
			wc_q        <= is_final ? '0 : wc_q + lpse_pkg::WC_W'(1);
			spi_valid_q <= 1'b1;
		end else if (spi_ready) begin
			spi_valid_q <= 1'b0;
		end
	end

	// hold the word until it is taken
	always_ff @(posedge clk) begin
		if (load) begin
			data_q  <= word;
			count_q <= is_tail ? lpse_pkg::BYTES_TAIL : lpse_pkg::BYTES_FULL;
			end_q   <= is_final && head.last;
		end
	end

	assign spi_valid  = spi_valid_q;
	assign spi_data   = data_q;
	assign byte_count = count_q;
	assign frame_end  = end_q;

endmodule

### hdl/led_pixel_spi_frame_encoder.sv
// channel   direction  handshake                  word
// pixel     in         pixel_valid / pixel_ready  red, green, blue
// spi       out        spi_valid / spi_ready      spi_data, byte_count, frame_end
// cfg       in         cfg_we                     cfg_index, cfg_data
//
// Each pixel goes out as green, red and blue words; the last pixel of a
// frame adds the reset gap words. The back end issues one word per
// cycle unless spi_ready stalls or the queue is empty. A two-entry pixel
// queue sits between the scaler and the word sequencer. arst_n clears
// position to 0, brightness to 128 and led_count to 1. A stalled spi_ready
// holds the output word and fills the queue before pixel_ready drops.
module led_pixel_spi_frame_encoder (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [lpse_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [lpse_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                 pixel_valid,
	output logic                                 pixel_ready,
	input  logic [lpse_pkg::COLOR_W-1:0]         red,
	input  logic [lpse_pkg::COLOR_W-1:0]         green,
	input  logic [lpse_pkg::COLOR_W-1:0]         blue,
	output logic                                 spi_valid,
	input  logic                                 spi_ready,
	output logic [lpse_pkg::WORD_W-1:0]          spi_data,
	output logic [lpse_pkg::CNT_W-1:0]           byte_count,
	output logic                                 frame_end
);

	lpse_pkg::pix_t q_wdata, q_rdata;
	logic           q_push, q_pop, q_full, q_nonempty;

	lpse_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.pixel_valid (pixel_valid),
		.pixel_ready (pixel_ready),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_wdata     (q_wdata)
	);

	lpse_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.wdata    (q_wdata),
		.pop      (q_pop),
		.rdata    (q_rdata),
		.full     (q_full),
		.nonempty (q_nonempty)
	);

	lpse_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (q_rdata),
		.head_valid (q_nonempty),
		.q_pop      (q_pop),
		.spi_valid  (spi_valid),
		.spi_ready  (spi_ready),
		.spi_data   (spi_data),
		.byte_count (byte_count),
		.frame_end  (frame_end)
	);

endmodule

### hdl/lpse_checker.sv
module lpse_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            spi_valid,
	input logic                            spi_ready,
	input logic [lpse_pkg::WORD_W-1:0]     spi_data,
	input logic [lpse_pkg::CNT_W-1:0]      byte_count,
	input logic                            frame_end
);

	// stalled word must hold
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		spi_valid && !spi_ready |=> spi_valid && $stable(spi_data) &&
		$stable(byte_count) && $stable(frame_end))
		else $error("spi word changed while stalled");

	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		spi_valid |-> byte_count != '0)
		else $error("spi word with zero bytes");

	// only the closing gap word may be short
	a_short_is_end: assert property (@(posedge clk) disable iff (!arst_n)
		spi_valid && byte_count != lpse_pkg::BYTES_FULL |-> frame_end)
		else $error("short spi word not at frame end");

	a_end_is_gap: assert property (@(posedge clk) disable iff (!arst_n)
		spi_valid && frame_end |-> (lpse_pkg::GAP_WORDS == 0) ||
		(spi_data == '0 && byte_count == lpse_pkg::BYTES_TAIL))
		else $error("frame end word is not the gap tail");

endmodule

bind led_pixel_spi_frame_encoder lpse_checker u_lpse_checker (.*);

### dv/tb.sv
`timescale 1ns / 100ps

module tb;

	localparam int STALL_LIMIT = 3000;
	localparam int N_DIR       = 35;
	localparam int N_PHASES    = 12;
	localparam int PHASE_ITEMS = 25;
	localparam int TAIL_CYCLES = 40;

	typedef enum logic {ROW_PIX, ROW_REG} row_kind_t;

	typedef struct packed {
		row_kind_t                       kind;
		logic [lpse_pkg::CFG_IDX_W-1:0]  idx;
		logic [lpse_pkg::CFG_DATA_W-1:0] value;
		logic [lpse_pkg::COLOR_W-1:0]    red;
		logic [lpse_pkg::COLOR_W-1:0]    green;
		logic [lpse_pkg::COLOR_W-1:0]    blue;
		logic                            known;
		logic [lpse_pkg::WORD_W-1:0]     word;
	} row_t;

	typedef struct packed {
		logic [lpse_pkg::WORD_W-1:0] data;
		logic [lpse_pkg::CNT_W-1:0]  count;
		logic                        fend;
	} spi_word_t;

	logic                            clk;
	logic                            arst_n;
	logic                            cfg_we;
	logic [lpse_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [lpse_pkg::CFG_DATA_W-1:0] cfg_data;
	logic                            pixel_valid;
	logic                            pixel_ready;
	logic [lpse_pkg::COLOR_W-1:0]    red;
	logic [lpse_pkg::COLOR_W-1:0]    green;
	logic [lpse_pkg::COLOR_W-1:0]    blue;
	logic                            spi_valid;
	logic                            spi_ready = 1'b0;
	logic [lpse_pkg::WORD_W-1:0]     spi_data;
	logic [lpse_pkg::CNT_W-1:0]      byte_count;
	logic                            frame_end;

	// predictor state
	logic [lpse_pkg::BRIGHT_W-1:0] bright_reg;
	logic [lpse_pkg::LEN_W-1:0]    len_reg;
	logic [lpse_pkg::POS_W-1:0]    frame_pos;

	spi_word_t spi_words_due[$];
	spi_word_t due;
	row_t      dir_rows [0:N_DIR-1];
	int        errors = 0;
	int        snd_idle = 0;
	int        rcv_idle = 0;

	led_pixel_spi_frame_encoder dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.pixel_valid(pixel_valid),
		.pixel_ready(pixel_ready),
		.red(red),
		.green(green),
		.blue(blue),
		.spi_valid(spi_valid),
		.spi_ready(spi_ready),
		.spi_data(spi_data),
		.byte_count(byte_count),
		.frame_end(frame_end)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [lpse_pkg::COLOR_W-1:0] scale_color(
			input logic [lpse_pkg::COLOR_W-1:0] c);
		logic [15:0] prod;
		prod = c * bright_reg;
		return prod[15:8];
	endfunction

	function automatic logic [lpse_pkg::WORD_W-1:0] spi_pattern(
			input logic [lpse_pkg::COLOR_W-1:0] v);
		logic [lpse_pkg::WORD_W-1:0] w;
		w = '0;
		for (int k = lpse_pkg::COLOR_W - 1; k >= 0; k--)
			w = {w[lpse_pkg::WORD_W-4:0], v[k] ? lpse_pkg::PAT_ONE : lpse_pkg::PAT_ZERO};
		return w;
	endfunction

	// push the G, R, B words of one pixel and the reset gap if it closes the frame
	task automatic queue_pixel_words(input logic [lpse_pkg::COLOR_W-1:0] r, g, b,
			input logic known, input logic [lpse_pkg::WORD_W-1:0] word);
		logic [lpse_pkg::LEN_W-1:0] flen;
		logic                       last;
		int                         left;
		int                         cnt;
		spi_word_t                  w;
		flen = len_reg;
		if (flen == '0)
			flen = lpse_pkg::LEN_W'(1);
		if (flen > lpse_pkg::MAX_LEN)
			flen = lpse_pkg::MAX_LEN;
		last = ({1'b0, frame_pos} + 11'd1) >= flen;
		w = '{known ? word : spi_pattern(scale_color(g)), lpse_pkg::BYTES_FULL, 1'b0};
		spi_words_due.push_back(w);
		w = '{known ? word : spi_pattern(scale_color(r)), lpse_pkg::BYTES_FULL, 1'b0};
		spi_words_due.push_back(w);
		w = '{known ? word : spi_pattern(scale_color(b)), lpse_pkg::BYTES_FULL,
			last && (lpse_pkg::RESET_GAP_BYTES == 0)};
		spi_words_due.push_back(w);
		if (last) begin
			left = lpse_pkg::RESET_GAP_BYTES;
			while (left > 0) begin
				cnt = (left > 3) ? 3 : left;
				left -= cnt;
				w = '{'0, lpse_pkg::CNT_W'(cnt), left == 0};
				spi_words_due.push_back(w);
			end
			frame_pos = '0;
		end else begin
			frame_pos = frame_pos + 1'b1;
		end
	endtask

	task automatic send_pixel(input logic [lpse_pkg::COLOR_W-1:0] r, g, b,
			input logic known, input logic [lpse_pkg::WORD_W-1:0] word);
		logic ok;
		while ($urandom_range(99) < snd_idle) begin
			pixel_valid <= 1'b0;
			@(posedge clk);
		end
		pixel_valid <= 1'b1;
		red         <= r;
		green       <= g;
		blue        <= b;
		queue_pixel_words(r, g, b, known, word);
		// inputs only move at the rising edge, so ready seen at the falling edge holds
		forever begin
			@(negedge clk);
			ok = pixel_ready;
			@(posedge clk);
			if (ok)
				break;
		end
	endtask

	task automatic drain();
		pixel_valid <= 1'b0;
		while (spi_words_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [lpse_pkg::CFG_IDX_W-1:0] idx,
			input logic [lpse_pkg::CFG_DATA_W-1:0] value);
		drain();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		if (idx == lpse_pkg::REG_BRIGHTNESS)
			bright_reg = value[lpse_pkg::BRIGHT_W-1:0];
		else
			len_reg = value[lpse_pkg::LEN_W-1:0];
	endtask

	always @(posedge clk) begin
		spi_ready <= ($urandom_range(99) >= rcv_idle);
	end

	always @(negedge clk) begin
		if (arst_n && spi_valid && spi_ready) begin
			if (spi_words_due.size() == 0) begin
				$error("spi word with nothing due: spi_data %h", spi_data);
				errors++;
			end else begin
				due = spi_words_due.pop_front();
				if (spi_data !== due.data) begin
					$error("spi_data: expected %h, got %h", due.data, spi_data);
					errors++;
				end
				if (byte_count !== due.count) begin
					$error("byte_count: expected %0d, got %0d", due.count, byte_count);
					errors++;
				end
				if (frame_end !== due.fend) begin
					$error("frame_end: expected %0b, got %0b", due.fend, frame_end);
					errors++;
				end
			end
		end
	end

	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(negedge clk);
			if ((pixel_valid && pixel_ready) || (spi_valid && spi_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		arst_n      = 1'b0;
		cfg_we      = 1'b0;
		cfg_index   = lpse_pkg::REG_BRIGHTNESS;
		cfg_data    = '0;
		pixel_valid = 1'b0;
		red         = '0;
		green       = '0;
		blue        = '0;
		bright_reg  = lpse_pkg::BRIGHTNESS_RST;
		len_reg     = lpse_pkg::LED_COUNT_RST;
		frame_pos   = '0;

		dir_rows = '{
			'{ROW_PIX, lpse_pkg::REG_BRIGHTNESS, 11'd0, 8'hFF, 8'hFF, 8'hFF, 1'b1, 24'h9B6DB6},
			'{ROW_PIX, lpse_pkg::REG_BRIGHTNESS, 11'd0, 8'h00, 8'h00, 8'h00, 1'b1, 24'h924924},
			'{ROW_PIX, lpse_pkg::REG_BRIGHTNESS, 11'd0, 8'h80, 8'h01, 8'hAA, 1'b0, 24'h0},
			'{ROW_REG, lpse_pkg::REG_BRIGHTNESS, 11'd255, 8'h00, 8'h00, 8'h00, 1'b0, 24'h0},
			'{ROW_PIX, lpse_pkg::REG_BRIGHTNESS, 11'd0, 8'hFF, 8'hFF, 8'hFF, 1'b1, 24'hDB6DB4},
			'{ROW_PIX, lpse_pkg::REG_BRIGHTNESS, 11'd0, 8'h55, 8'hAA, 8'h0F, 1'b0, 24'h0},
			'{ROW_PIX, lpse_pkg::REG_BRIGHTNESS, 11'd0, 8'h00, 8'hFF, 8'h00, 1'b0, 24'h0},
			'{ROW_REG, lpse_pkg::REG_BRIGHTNESS, 11'd0, 8'h00, 8'h00, 8'h00, 1'b0, 24'h0},
			'{ROW_PIX, lpse_pkg::REG_BRIGHTNESS, 11'd0, 8'hFF, 8'h80, 8'h01, 1'b1, 24'h924924},
			'{ROW_REG, lpse_pkg::REG_BRIGHTNESS, 11'd255, 8'h00, 8'h00, 8'h00, 1'b0, 24'h0},
			// zero frame length: every pixel closes a frame
			'{ROW_REG, lpse_pkg::REG_LED_COUNT, 11'd0, 8'h00, 8'h00, 8'h00, 1'b0, 24'h0},
			'{ROW_PIX, lpse_pkg::REG_BRIGHTNESS, 11'd0, 8'h01, 8'h02, 8'h04, 1'b0, 24'h0},
			'{ROW_PIX, lpse_pkg::REG_BRIGHTNESS, 11'd0, 8'hC8, 8'h64, 8'h32, 1'b0, 24'h0},
			// oversized length clamps to the maximum
			'{ROW_REG, lpse_pkg::REG_LED_COUNT, 11'd2047, 8'h00, 8'h00, 8'h00, 1'b0, 24'h0},
			'{ROW_PIX, lpse_pkg::REG_BRIGHTNESS, 11'd0, 8'h7F, 8'hFE, 8'h81, 1'b0, 24'h0},
			'{ROW_PIX, lpse_pkg::REG_BRIGHTNESS, 11'd0, 8'hFF, 8'h00, 8'hFF, 1'b0, 24'h0},
			// shrink mid-frame: position already at the new length
			'{ROW_REG, lpse_pkg::REG_LED_COUNT, 11'd2, 8'h00, 8'h00, 8'h00, 1'b0, 24'h0},
			'{ROW_PIX, lpse_pkg::REG_BRIGHTNESS, 11'd0, 8'h10, 8'h20, 8'h40, 1'b0, 24'h0},
			'{ROW_PIX, lpse_pkg::REG_BRIGHTNESS, 11'd0, 8'h3C, 8'hC3, 8'h99, 1'b0, 24'h0},
			'{ROW_PIX, lpse_pkg::REG_BRIGHTNESS, 11'd0, 8'h66, 8'h11, 8'hEE, 1'b0, 24'h0},
			'{ROW_PIX, lpse_pkg::REG_BRIGHTNESS, 11'd0, 8'hFF, 8'hFF, 8'hFF, 1'b1, 24'hDB6DB4},
			'{ROW_REG, lpse_pkg::REG_LED_COUNT, 11'd6, 8'h00, 8'h00, 8'h00, 1'b0, 24'h0},
			'{ROW_PIX, lpse_pkg::REG_BRIGHTNESS, 11'd0, 8'h5A, 8'hA5, 8'hC3, 1'b0, 24'h0},
			'{ROW_PIX, lpse_pkg::REG_BRIGHTNESS, 11'd0, 8'h0F, 8'hF0, 8'h33, 1'b0, 24'h0},
			'{ROW_PIX, lpse_pkg::REG_BRIGHTNESS, 11'd0, 8'h81, 8'h18, 8'h42, 1'b0, 24'h0},
			'{ROW_PIX, lpse_pkg::REG_BRIGHTNESS, 11'd0, 8'hE7, 8'h7E, 8'h24, 1'b0, 24'h0},
			'{ROW_REG, lpse_pkg::REG_LED_COUNT, 11'd2, 8'h00, 8'h00, 8'h00, 1'b0, 24'h0},
			'{ROW_PIX, lpse_pkg::REG_BRIGHTNESS, 11'd0, 8'h12, 8'h34, 8'h56, 1'b0, 24'h0},
			'{ROW_PIX, lpse_pkg::REG_BRIGHTNESS, 11'd0, 8'h9A, 8'hBC, 8'hDE, 1'b0, 24'h0},
			'{ROW_PIX, lpse_pkg::REG_BRIGHTNESS, 11'd0, 8'hF1, 8'hE2, 8'hD3, 1'b0, 24'h0},
			'{ROW_REG, lpse_pkg::REG_BRIGHTNESS, 11'd128, 8'h00, 8'h00, 8'h00, 1'b0, 24'h0},
			'{ROW_PIX, lpse_pkg::REG_BRIGHTNESS, 11'd0, 8'h01, 8'h01, 8'h01, 1'b1, 24'h924924},
			'{ROW_PIX, lpse_pkg::REG_BRIGHTNESS, 11'd0, 8'h02, 8'h02, 8'h02, 1'b0, 24'h0},
			'{ROW_REG, lpse_pkg::REG_BRIGHTNESS, 11'd1, 8'h00, 8'h00, 8'h00, 1'b0, 24'h0},
			'{ROW_PIX, lpse_pkg::REG_BRIGHTNESS, 11'd0, 8'hFF, 8'hFF, 8'hFF, 1'b1, 24'h924924}
		};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		snd_idle = 10;
		rcv_idle = 63;
		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_PIX)
				send_pixel(dir_rows[i].red, dir_rows[i].green, dir_rows[i].blue,
					dir_rows[i].known, dir_rows[i].word);
			else
				write_reg(dir_rows[i].idx, dir_rows[i].value);
		end

		for (int ph = 0; ph < N_PHASES; ph++) begin
			case (ph / 4)
				0: begin
					snd_idle = 10;
					rcv_idle = 63;
				end
				1: begin
					snd_idle = 63;
					rcv_idle = 10;
				end
				default: begin
					snd_idle = 0;
					rcv_idle = 0;
				end
			endcase
			case ($urandom_range(3))
				0: write_reg(lpse_pkg::REG_BRIGHTNESS, 11'd0);
				1: write_reg(lpse_pkg::REG_BRIGHTNESS, 11'd255);
				default: write_reg(lpse_pkg::REG_BRIGHTNESS,
					lpse_pkg::CFG_DATA_W'($urandom_range(255)));
			endcase
			// keep frames short mostly so the reset gap shows up often
			case ($urandom_range(9))
				0: write_reg(lpse_pkg::REG_LED_COUNT, 11'd0);
				1: write_reg(lpse_pkg::REG_LED_COUNT, 11'd2047);
				2: write_reg(lpse_pkg::REG_LED_COUNT, 11'd1024);
				3: write_reg(lpse_pkg::REG_LED_COUNT,
					lpse_pkg::CFG_DATA_W'($urandom_range(1024, 1)));
				default: write_reg(lpse_pkg::REG_LED_COUNT,
					lpse_pkg::CFG_DATA_W'($urandom_range(6, 1)));
			endcase
			repeat (PHASE_ITEMS)
				send_pixel(lpse_pkg::COLOR_W'($urandom_range(255)),
					lpse_pkg::COLOR_W'($urandom_range(255)),
					lpse_pkg::COLOR_W'($urandom_range(255)), 1'b0, '0);
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0 && spi_words_due.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
